// File: rtl/snp_pkg.sv
// Shared types, constants and tables for the nearest scan point drive block.
package snp_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int RANGE_W    = 17;
    localparam int ANGLE_W    = 16;
    localparam int BEAM_W     = 20;
    localparam int STEP_W     = 14;
    localparam int GAIN_W     = 16;
    localparam int POS_W      = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam int ATAN_IDX_W = 5;
    localparam int CORDIC_W   = 36;
    localparam int ZANG_W     = 32;
    localparam int RND_W      = 21;
    localparam int PROD_W     = 35;
    localparam int INV_W      = 30;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RANGE_W-1:0]        RANGE_CAP     = 17'd102400;
    localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 16'sd12868;
    localparam logic [INV_W-1:0]          INV_GAIN_Q30  = 30'd652032874;

    localparam logic signed [ANGLE_W-1:0] START_RESET = -16'sd18000;
    localparam logic signed [STEP_W-1:0]  STEP_RESET  = 14'sd50;
    localparam logic [GAIN_W-1:0]         LIN_RESET   = 16'd13107;
    localparam logic [GAIN_W-1:0]         ANG_RESET   = 16'd26214;
    localparam logic [RANGE_W-1:0]        STOP_RESET  = 17'd512;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_ANGLE  = 3'd0,
        REG_ANGLE_STEP   = 3'd1,
        REG_LINEAR_GAIN  = 3'd2,
        REG_ANGULAR_GAIN = 3'd3,
        REG_STOP_DIST    = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] start_angle;
        logic signed [STEP_W-1:0]  angle_step;
        logic [GAIN_W-1:0]         linear_gain;
        logic [GAIN_W-1:0]         angular_gain;
        logic [RANGE_W-1:0]        stop_distance;
    } t_cfg;

    typedef struct packed {
        logic [RANGE_W-1:0]        range;
        logic signed [ANGLE_W-1:0] angle;
    } t_scan_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_ROT,
        S_ROUND,
        S_SAT,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_T,
        S_DONE,
        S_PUSH
    } t_back_state;

    function automatic logic signed [ZANG_W-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ZANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd421657428;
            5'd1:    v = 32'sd248918915;
            5'd2:    v = 32'sd131521919;
            5'd3:    v = 32'sd66762579;
            5'd4:    v = 32'sd33510843;
            5'd5:    v = 32'sd16771758;
            5'd6:    v = 32'sd8387926;
            5'd7:    v = 32'sd4194219;
            5'd8:    v = 32'sd2097141;
            5'd9:    v = 32'sd1048575;
            5'd10:   v = 32'sd524288;
            5'd11:   v = 32'sd262144;
            5'd12:   v = 32'sd131072;
            5'd13:   v = 32'sd65536;
            5'd14:   v = 32'sd32768;
            5'd15:   v = 32'sd16384;
            5'd16:   v = 32'sd8192;
            5'd17:   v = 32'sd4096;
            5'd18:   v = 32'sd2048;
            5'd19:   v = 32'sd1024;
            5'd20:   v = 32'sd512;
            5'd21:   v = 32'sd256;
            5'd22:   v = 32'sd128;
            5'd23:   v = 32'sd64;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/snp_front.sv
// Front end: tracks the nearest beam of a scan and queues one record per scan end.
module snp_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  snp_pkg::t_cfg             i_cfg,
    input  logic                      i_start_load,
    input  logic [snp_pkg::ANGLE_W-1:0] i_start_value,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [snp_pkg::RANGE_W-1:0] i_range,
    input  logic                      i_last,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output snp_pkg::t_scan_rec        o_q_rec
);
    import snp_pkg::*;

    logic [RANGE_W-1:0]        r_best;
    logic signed [ANGLE_W-1:0] r_held;
    logic signed [BEAM_W-1:0]  r_beam;

    logic                      accept;
    logic                      hit;
    logic signed [ANGLE_W-1:0] beam_sat;
    logic [RANGE_W-1:0]        n_best;
    logic signed [ANGLE_W-1:0] n_held;
    logic signed [BEAM_W-1:0]  n_beam;

    assign o_ready = ~i_q_full;
    assign accept  = i_valid & ~i_q_full;
    assign hit     = i_range < r_best;

    always_comb begin
        if (r_beam > BEAM_W'(ANGLE_PI)) begin
            beam_sat = ANGLE_PI;
        end else if (r_beam < -BEAM_W'(ANGLE_PI)) begin
            beam_sat = -ANGLE_PI;
        end else begin
            beam_sat = r_beam[ANGLE_W-1:0];
        end
    end

    assign n_best = hit ? i_range : r_best;
    assign n_held = hit ? beam_sat : r_held;
    assign n_beam = r_beam + BEAM_W'(i_cfg.angle_step);

    assign o_q_push      = accept & i_last;
    assign o_q_rec.range = n_best;
    assign o_q_rec.angle = n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= RANGE_CAP;
            r_held <= '0;
            r_beam <= BEAM_W'(START_RESET);
        end else if (accept) begin
            r_held <= n_held;
            if (i_last) begin
                r_best <= RANGE_CAP;
                r_beam <= BEAM_W'(i_cfg.start_angle);
            end else begin
                r_best <= n_best;
                r_beam <= n_beam;
            end
        end else if (i_start_load) begin
            r_beam <= BEAM_W'($signed(i_start_value));
        end
    end

endmodule

// File: rtl/snp_queue.sv
// Short record queue between the front end and the back end.
module snp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  snp_pkg::t_scan_rec i_rec,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output snp_pkg::t_scan_rec o_rec
);
    import snp_pkg::*;

    t_scan_rec          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;

    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/snp_back.sv
// Back end: CORDIC rotation, saturation, gain products and the result register.
module snp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  snp_pkg::t_cfg              i_cfg,
    input  logic                       i_q_empty,
    input  snp_pkg::t_scan_rec         i_q_rec,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [snp_pkg::POS_W-1:0]   o_point_x,
    output logic [snp_pkg::POS_W-1:0]   o_point_y,
    output logic [snp_pkg::ANGLE_W-1:0] o_point_angle,
    output logic [snp_pkg::POS_W-1:0]   o_drive_x,
    output logic [snp_pkg::POS_W-1:0]   o_drive_y,
    output logic [snp_pkg::ANGLE_W-1:0] o_turn_rate,
    output logic                       o_stopped
);
    import snp_pkg::*;

    localparam logic signed [RND_W-1:0] POS_LIM = RND_W'(RANGE_CAP);

    t_back_state r_state;
    t_back_state n_state;

    logic [RANGE_W-1:0]         r_range;
    logic signed [ANGLE_W-1:0]  r_angle;
    logic                       r_flip;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [ZANG_W-1:0]   r_z;
    logic [ATAN_IDX_W-1:0]      r_step;
    logic signed [RND_W-1:0]    r_rx;
    logic signed [RND_W-1:0]    r_ry;
    logic signed [POS_W-1:0]    r_px;
    logic signed [POS_W-1:0]    r_py;
    logic                       r_stop;
    logic signed [PROD_W-1:0]   r_prod;
    logic [POS_W-1:0]           r_dx;
    logic [POS_W-1:0]           r_dy;
    logic [ANGLE_W-1:0]         r_tr;

    logic                       r_o_valid;
    logic [POS_W-1:0]           r_o_px;
    logic [POS_W-1:0]           r_o_py;
    logic [ANGLE_W-1:0]         r_o_ang;
    logic [POS_W-1:0]           r_o_dx;
    logic [POS_W-1:0]           r_o_dy;
    logic [ANGLE_W-1:0]         r_o_tr;
    logic                       r_o_stop;

    logic                       load_out;
    logic                       out_free;
    logic                       rot_dir;
    logic signed [CORDIC_W-1:0] shift_x;
    logic signed [CORDIC_W-1:0] shift_y;
    logic signed [ZANG_W-1:0]   atan_v;
    logic signed [ANGLE_W:0]    adj_angle;
    logic [RANGE_W+INV_W-1:0]   scale_prod;
    logic signed [CORDIC_W-1:0] rnd_x;
    logic signed [CORDIC_W-1:0] rnd_y;
    logic signed [POS_W-1:0]    mul_a;
    logic signed [RANGE_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [RND_W-1:0]    sat_x_in;
    logic signed [RND_W-1:0]    sat_y_in;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RND_W-1:0] v);
        logic signed [POS_W-1:0] s;
        if (v > POS_LIM) begin
            s = POS_W'(POS_LIM);
        end else if (v < -POS_LIM) begin
            s = POS_W'(-POS_LIM);
        end else begin
            s = v[POS_W-1:0];
        end
        return s;
    endfunction

    assign out_free = ~r_o_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_ROT;
            S_ROT: begin
                if (r_step == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_SAT;
            S_SAT:   n_state = S_MUL_X;
            S_MUL_X: n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_MUL_T;
            S_MUL_T: n_state = S_DONE;
            S_DONE:  n_state = S_PUSH;
            S_PUSH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign rot_dir = ~r_z[ZANG_W-1];
    assign shift_x = r_x >>> r_step;
    assign shift_y = r_y >>> r_step;
    assign atan_v  = atan_q29(r_step);

    always_comb begin
        if (!r_flip) begin
            adj_angle = (ANGLE_W+1)'(r_angle);
        end else if (r_angle > 0) begin
            adj_angle = (ANGLE_W+1)'(r_angle) - (ANGLE_W+1)'(ANGLE_PI);
        end else begin
            adj_angle = (ANGLE_W+1)'(r_angle) + (ANGLE_W+1)'(ANGLE_PI);
        end
    end

    assign scale_prod = (RANGE_W+INV_W)'(r_range) * (RANGE_W+INV_W)'(INV_GAIN_Q30);
    assign rnd_x      = (r_x + CORDIC_W'(32768)) >>> 16;
    assign rnd_y      = (r_y + CORDIC_W'(32768)) >>> 16;
    assign sat_x_in   = r_rx;
    assign sat_y_in   = r_ry;

    always_comb begin
        case (r_state)
            S_MUL_Y: begin
                mul_a = r_py;
                mul_b = $signed({1'b0, i_cfg.linear_gain});
            end
            S_MUL_T: begin
                mul_a = -POS_W'(r_angle);
                mul_b = $signed({1'b0, i_cfg.angular_gain});
            end
            default: begin
                mul_a = r_px;
                mul_b = $signed({1'b0, i_cfg.linear_gain});
            end
        endcase
    end

    assign prod_rnd = (r_prod + PROD_W'(32768)) >>> 16;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_range <= i_q_rec.range;
                r_angle <= i_q_rec.angle;
                r_flip  <= (i_q_rec.angle > ANGLE_HALF_PI) || (i_q_rec.angle < -ANGLE_HALF_PI);
            end
            S_SCALE: begin
                r_x    <= CORDIC_W'(scale_prod >> 14);
                r_y    <= '0;
                r_z    <= ZANG_W'(adj_angle) <<< 16;
                r_step <= '0;
            end
            S_ROT: begin
                if (rot_dir) begin
                    r_x <= r_x - shift_y;
                    r_y <= r_y + shift_x;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + shift_y;
                    r_y <= r_y - shift_x;
                    r_z <= r_z + atan_v;
                end
                r_step <= r_step + 1'b1;
            end
            S_ROUND: begin
                r_rx <= r_flip ? -rnd_x[RND_W-1:0] : rnd_x[RND_W-1:0];
                r_ry <= r_flip ? -rnd_y[RND_W-1:0] : rnd_y[RND_W-1:0];
            end
            S_SAT: begin
                r_px <= sat_pos(sat_x_in);
                r_py <= sat_pos(sat_y_in);
            end
            S_MUL_X: begin
                r_stop <= $signed({r_px[POS_W-1], r_px}) <= $signed({2'b00, i_cfg.stop_distance});
                r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            S_MUL_Y: begin
                r_dx   <= prod_rnd[POS_W-1:0];
                r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            S_MUL_T: begin
                r_dy   <= prod_rnd[POS_W-1:0];
                r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            S_DONE: begin
                r_tr <= prod_rnd[ANGLE_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_px   <= r_px;
            r_o_py   <= r_py;
            r_o_ang  <= r_angle;
            r_o_dx   <= r_stop ? '0 : r_dx;
            r_o_dy   <= r_stop ? '0 : r_dy;
            r_o_tr   <= r_stop ? '0 : r_tr;
            r_o_stop <= r_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_point_x     = r_o_px;
    assign o_point_y     = r_o_py;
    assign o_point_angle = r_o_ang;
    assign o_drive_x     = r_o_dx;
    assign o_drive_y     = r_o_dy;
    assign o_turn_rate   = r_o_tr;
    assign o_stopped     = r_o_stop;

endmodule

// File: rtl/scan_nearest_point_p_drive.sv
// Top level of the nearest scan point proportional drive block.
//
//  Channel   Signals                                 Content
//  s_axis    tvalid tready tdata[23:0] tlast         one range sample per beat, tlast ends a scan
//  m_axis    tvalid tready tdata[103:0] tuser[0:0]   one result per scan
//  cfg       i_cfg_we i_cfg_addr i_cfg_data          register writes, no read-back
//
// Samples are taken one per cycle while the queue has room; the nearest-beam search keeps up with the input.
// Each scan end places one record in a two-entry queue; the back end takes the next record
// only when it is done with the last, as it works with a single iterative CORDIC stage.
// The input stalls only while the queue holds two unprocessed scan ends.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled result waits in the output register while new samples keep arriving.
module scan_nearest_point_p_drive (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [snp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [snp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // range_sample[16:0], zero pad [23:17]
    input  logic [23:0]                     s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // point_x[17:0], point_y[35:18], point_angle[51:36], drive_x[69:52],
    // drive_y[87:70], turn_rate[103:88]
    output logic [103:0]                    m_axis_tdata,
    // stopped[0]
    output logic [0:0]                      m_axis_tuser
);
    import snp_pkg::*;

    t_cfg      r_cfg;
    logic      start_load;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    t_scan_rec q_in;
    t_scan_rec q_out;

    logic [POS_W-1:0]   point_x;
    logic [POS_W-1:0]   point_y;
    logic [ANGLE_W-1:0] point_angle;
    logic [POS_W-1:0]   drive_x;
    logic [POS_W-1:0]   drive_y;
    logic [ANGLE_W-1:0] turn_rate;
    logic               stopped;

    assign start_load = i_cfg_we && (i_cfg_addr == REG_START_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_angle   <= START_RESET;
            r_cfg.angle_step    <= STEP_RESET;
            r_cfg.linear_gain   <= LIN_RESET;
            r_cfg.angular_gain  <= ANG_RESET;
            r_cfg.stop_distance <= STOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_START_ANGLE:  r_cfg.start_angle   <= i_cfg_data[ANGLE_W-1:0];
                REG_ANGLE_STEP:   r_cfg.angle_step    <= i_cfg_data[STEP_W-1:0];
                REG_LINEAR_GAIN:  r_cfg.linear_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_ANGULAR_GAIN: r_cfg.angular_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_STOP_DIST:    r_cfg.stop_distance <= i_cfg_data[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    snp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_start_load  (start_load),
        .i_start_value (i_cfg_data[ANGLE_W-1:0]),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_range       (s_axis_tdata[RANGE_W-1:0]),
        .i_last        (s_axis_tlast),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_rec       (q_in)
    );

    snp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (q_out)
    );

    snp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (q_empty),
        .i_q_rec       (q_out),
        .o_q_pop       (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_point_x     (point_x),
        .o_point_y     (point_y),
        .o_point_angle (point_angle),
        .o_drive_x     (drive_x),
        .o_drive_y     (drive_y),
        .o_turn_rate   (turn_rate),
        .o_stopped     (stopped)
    );

    assign m_axis_tdata = {turn_rate, drive_y, drive_x, point_angle, point_y, point_x};
    assign m_axis_tuser = stopped;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("scan record pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_stopped_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (drive_x == '0 && drive_y == '0 && turn_rate == '0))
        else $error("stopped result carries a nonzero drive");

    a_point_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        ($signed(point_x) <= $signed(POS_W'(RANGE_CAP)) &&
         $signed(point_x) >= -$signed(POS_W'(RANGE_CAP))))
        else $error("point_x outside the saturation limit");

endmodule

// File: sim/scan_nearest_point_p_drive_test.sv
// Self-checking testbench for the nearest scan point drive block, directed and random scans.
`timescale 1ns / 1ps

module scan_nearest_point_p_drive_test;
    import snp_pkg::*;

    localparam int     RANGE_MAX    = 131071;
    localparam longint NEAR_CAP     = 102400;
    localparam longint PI_Q13       = 25736;
    localparam longint HALF_PI_Q13  = 12868;
    localparam longint INV_GAIN     = 652032874;
    localparam int     REG_SPARE_LO = 5;
    localparam int     REG_SPARE_HI = 7;
    localparam int     DRAIN_CYCLES = CORDIC_STEPS + 40;
    localparam int     HOLD_AFTER   = 15;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_BEAMS  = 205;
    localparam int     LONG_SCAN    = 200;
    localparam int     FAULT_SHOWN  = 10;

    typedef struct packed {
        logic [RANGE_W-1:0] range_sample;
        logic               scan_end;
    } beam_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   point_x;
        logic signed [POS_W-1:0]   point_y;
        logic signed [ANGLE_W-1:0] point_angle;
        logic signed [POS_W-1:0]   drive_x;
        logic signed [POS_W-1:0]   drive_y;
        logic signed [ANGLE_W-1:0] turn_rate;
        logic                      stopped;
    } drive_cmd_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // range_sample[16:0], zero pad [23:17]
    logic [23:0]           s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // point_x[17:0], point_y[35:18], point_angle[51:36], drive_x[69:52],
    // drive_y[87:70], turn_rate[103:88]
    logic [103:0]          m_axis_tdata;
    // stopped[0]
    logic [0:0]            m_axis_tuser;

    t_cfg                      drive_cfg;
    logic [RANGE_W-1:0]        near_range;
    logic signed [ANGLE_W-1:0] near_angle;
    logic signed [BEAM_W-1:0]  beam_angle;

    longint cordic_atan [24] = '{
        421657428, 248918915, 131521919, 66762579, 33510843, 16771758,
        8387926, 4194219, 2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096,
        2048, 1024, 512, 256, 128, 64
    };

    beam_t      beams_to_send[$];
    drive_cmd_t scan_results_due[$];
    beam_t      beam_on_bus = '0;
    bit         beam_held = 1'b0;
    bit         no_idle = 1'b0;
    int         send_gap = 0;
    int         ready_gap = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         results_seen = 0;
    int         result_faults = 0;
    drive_cmd_t got_cmd;
    drive_cmd_t want_cmd;

    scan_nearest_point_p_drive dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Tracks the nearest beam of the scan and, on the scan end, works out the result.
    function automatic void take_beam(input beam_t b);
        longint     x, y, z, nx, held, ang, px, py;
        logic       flip;
        logic       stop;
        int         i;
        drive_cmd_t cmd;
        if (b.range_sample < near_range) begin
            near_range = b.range_sample;
            if (beam_angle > PI_Q13) near_angle = ANGLE_W'(PI_Q13);
            else if (beam_angle < -PI_Q13) near_angle = ANGLE_W'(-PI_Q13);
            else near_angle = beam_angle[ANGLE_W-1:0];
        end
        beam_angle = beam_angle + $signed(drive_cfg.angle_step);
        if (!b.scan_end) return;

        held = longint'(near_angle);
        ang = held;
        flip = 1'b0;
        if (ang > HALF_PI_Q13) begin
            ang = ang - PI_Q13;
            flip = 1'b1;
        end else if (ang < -HALF_PI_Q13) begin
            ang = ang + PI_Q13;
            flip = 1'b1;
        end
        x = (longint'(near_range) * INV_GAIN) >>> 14;
        y = 0;
        z = ang * 65536;
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - cordic_atan[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + cordic_atan[i];
            end
            x = nx;
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip) begin
            x = -x;
            y = -y;
        end
        px = (x > NEAR_CAP) ? NEAR_CAP : ((x < -NEAR_CAP) ? -NEAR_CAP : x);
        py = (y > NEAR_CAP) ? NEAR_CAP : ((y < -NEAR_CAP) ? -NEAR_CAP : y);
        stop = px <= longint'(drive_cfg.stop_distance);

        cmd.point_x = px[POS_W-1:0];
        cmd.point_y = py[POS_W-1:0];
        cmd.point_angle = near_angle;
        cmd.stopped = stop;
        if (stop) begin
            cmd.drive_x = '0;
            cmd.drive_y = '0;
            cmd.turn_rate = '0;
        end else begin
            x = (px * longint'(drive_cfg.linear_gain) + 32768) >>> 16;
            y = (py * longint'(drive_cfg.linear_gain) + 32768) >>> 16;
            z = (-held * longint'(drive_cfg.angular_gain) + 32768) >>> 16;
            cmd.drive_x = x[POS_W-1:0];
            cmd.drive_y = y[POS_W-1:0];
            cmd.turn_rate = z[ANGLE_W-1:0];
        end
        scan_results_due.push_back(cmd);
        near_range = RANGE_W'(NEAR_CAP);
        beam_angle = BEAM_W'(drive_cfg.start_angle);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input longint value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_START_ANGLE: begin
                drive_cfg.start_angle = value[ANGLE_W-1:0];
                beam_angle = BEAM_W'($signed(value[ANGLE_W-1:0]));
            end
            REG_ANGLE_STEP:   drive_cfg.angle_step = value[STEP_W-1:0];
            REG_LINEAR_GAIN:  drive_cfg.linear_gain = value[GAIN_W-1:0];
            REG_ANGULAR_GAIN: drive_cfg.angular_gain = value[GAIN_W-1:0];
            REG_STOP_DIST:    drive_cfg.stop_distance = value[RANGE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_drive(input longint sa, st, lg, ag, sd);
        write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  $urandom_range(0, RANGE_MAX));
        write_reg(REG_START_ANGLE, sa);
        write_reg(REG_ANGLE_STEP, st);
        write_reg(REG_LINEAR_GAIN, lg);
        write_reg(REG_ANGULAR_GAIN, ag);
        write_reg(REG_STOP_DIST, sd);
    endtask

    task automatic settle();
        while (beams_to_send.size() != 0 || beam_held || scan_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            beam_held = 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_beam(beam_on_bus);
                beam_held = 1'b0;
            end
            if (!beam_held) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (beams_to_send.size() != 0) begin
                    if (!no_idle && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 7);
                    end else begin
                        beam_on_bus = beams_to_send.pop_front();
                        beam_held = 1'b1;
                    end
                end
                s_axis_tvalid <= beam_held;
                s_axis_tdata <= {7'd0, beam_on_bus.range_sample};
                s_axis_tlast <= beam_on_bus.scan_end;
            end
        end
    end

    // The one long hold-off lets the scan record queue fill so that the input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_gap = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (ready_gap != 0) begin
            ready_gap--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            ready_gap = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_cmd.point_x = m_axis_tdata[17:0];
            got_cmd.point_y = m_axis_tdata[35:18];
            got_cmd.point_angle = m_axis_tdata[51:36];
            got_cmd.drive_x = m_axis_tdata[69:52];
            got_cmd.drive_y = m_axis_tdata[87:70];
            got_cmd.turn_rate = m_axis_tdata[103:88];
            got_cmd.stopped = m_axis_tuser[0];
            results_seen++;
            if (scan_results_due.size() == 0) begin
                if (result_faults < FAULT_SHOWN)
                    $display("result beat %0d arrived with none pending: x=%0d y=%0d",
                             results_seen, got_cmd.point_x, got_cmd.point_y);
                result_faults++;
            end else begin
                want_cmd = scan_results_due.pop_front();
                if (got_cmd.point_x !== want_cmd.point_x
                        || got_cmd.point_y !== want_cmd.point_y
                        || got_cmd.point_angle !== want_cmd.point_angle
                        || got_cmd.drive_x !== want_cmd.drive_x
                        || got_cmd.drive_y !== want_cmd.drive_y
                        || got_cmd.turn_rate !== want_cmd.turn_rate
                        || got_cmd.stopped !== want_cmd.stopped) begin
                    if (result_faults < FAULT_SHOWN) begin
                        $display("beat %0d want x=%0d y=%0d ang=%0d dx=%0d dy=%0d tr=%0d st=%0d",
                                 results_seen, want_cmd.point_x, want_cmd.point_y,
                                 want_cmd.point_angle, want_cmd.drive_x, want_cmd.drive_y,
                                 want_cmd.turn_rate, want_cmd.stopped);
                        $display("    actual x=%0d y=%0d ang=%0d dx=%0d dy=%0d tr=%0d st=%0d",
                                 got_cmd.point_x, got_cmd.point_y, got_cmd.point_angle,
                                 got_cmd.drive_x, got_cmd.drive_y, got_cmd.turn_rate,
                                 got_cmd.stopped);
                    end
                    result_faults++;
                end
            end
        end
    end

    initial begin
        int phase, sent, len, r, last_r, n, tail;
        int sa, st, lg, ag, sd;
        drive_cfg.start_angle = START_RESET;
        drive_cfg.angle_step = STEP_RESET;
        drive_cfg.linear_gain = LIN_RESET;
        drive_cfg.angular_gain = ANG_RESET;
        drive_cfg.stop_distance = STOP_RESET;
        near_range = RANGE_CAP;
        near_angle = '0;
        beam_angle = BEAM_W'(START_RESET);
        last_r = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: cap and ties are not taken, a scan with nothing under the cap
        // keeps the held angle, and a rear angle takes the flipped rotation.
        beams_to_send.push_back(beam_t'{17'd131071, 1'b0});
        beams_to_send.push_back(beam_t'{17'd102400, 1'b0});
        beams_to_send.push_back(beam_t'{17'd102399, 1'b0});
        beams_to_send.push_back(beam_t'{17'd102399, 1'b0});
        beams_to_send.push_back(beam_t'{17'd60000, 1'b0});
        beams_to_send.push_back(beam_t'{17'd60000, 1'b1});
        beams_to_send.push_back(beam_t'{17'd131071, 1'b1});
        beams_to_send.push_back(beam_t'{17'd0, 1'b1});
        settle();

        program_drive(0, 4096, 65535, 65535, 0);
        beams_to_send.push_back(beam_t'{17'd50000, 1'b0});
        beams_to_send.push_back(beam_t'{17'd40000, 1'b0});
        beams_to_send.push_back(beam_t'{17'd131071, 1'b0});
        beams_to_send.push_back(beam_t'{17'd30000, 1'b0});
        beams_to_send.push_back(beam_t'{17'd20000, 1'b0});
        beams_to_send.push_back(beam_t'{17'd70000, 1'b1});
        beams_to_send.push_back(beam_t'{17'd1, 1'b1});
        beams_to_send.push_back(beam_t'{17'd90000, 1'b0});
        beams_to_send.push_back(beam_t'{17'd80000, 1'b1});
        settle();

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == RAND_PHASES - 1) no_idle = 1'b1;
            case (phase)
                0: begin
                    sa = int'(-PI_Q13); st = 4096; lg = 65535; ag = 65535; sd = 0;
                end
                1: begin
                    sa = int'(PI_Q13); st = -4096; lg = 0; ag = 0; sd = RANGE_MAX;
                end
                2: begin
                    sa = 0; st = 0;
                    lg = $urandom_range(0, 65535);
                    ag = $urandom_range(0, 65535);
                    sd = $urandom_range(0, 2048);
                end
                default: begin
                    sa = int'($urandom_range(0, 51472)) - 25736;
                    if ($urandom_range(0, 1)) st = int'($urandom_range(0, 400)) - 200;
                    else st = int'($urandom_range(0, 8192)) - 4096;
                    lg = $urandom_range(0, 65535);
                    ag = $urandom_range(0, 65535);
                    if ($urandom_range(0, 1)) sd = $urandom_range(0, 2048);
                    else sd = $urandom_range(0, RANGE_MAX);
                end
            endcase
            program_drive(sa, st, lg, ag, sd);

            sent = 0;
            while (sent < PHASE_BEAMS) begin
                if (phase < 2 && sent == 0) len = LONG_SCAN;
                else if ($urandom_range(0, 19) == 0) len = $urandom_range(20, 60);
                else len = $urandom_range(1, 10);
                for (n = 0; n < len; n++) begin
                    case ($urandom_range(0, 7))
                        0: r = $urandom_range(0, RANGE_MAX);
                        1: r = $urandom_range(NEAR_CAP, RANGE_MAX);
                        2: r = last_r;
                        3: begin
                            case ($urandom_range(0, 3))
                                0: r = 0;
                                1: r = int'(NEAR_CAP - 1);
                                2: r = int'(NEAR_CAP);
                                default: r = RANGE_MAX;
                            endcase
                        end
                        default: r = $urandom_range(0, 12000);
                    endcase
                    last_r = r;
                    beams_to_send.push_back(beam_t'{r[RANGE_W-1:0], n == len - 1});
                end
                sent += len;
            end
            // A scan is left open; the next start angle write resets only its beam angle.
            if ($urandom_range(0, 1)) begin
                tail = $urandom_range(1, 5);
                for (n = 0; n < tail; n++)
                    beams_to_send.push_back(beam_t'{17'($urandom_range(0, RANGE_MAX)), 1'b0});
            end
            settle();
        end

        if (result_faults == 0 && scan_results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/snp_pkg.sv
rtl/snp_front.sv
rtl/snp_queue.sv
rtl/snp_back.sv
rtl/scan_nearest_point_p_drive.sv
sim/scan_nearest_point_p_drive_test.sv
